/* design/dq_pkg.sv */
// dq_pkg: shared widths, request and status codes, and item types for the
// double-ended queue. No dependencies; used by every design file.
`default_nettype none

package dq_pkg;

    // Ring capacity (2..64) and the widths that follow from it
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_WALK       = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW   = 2'd2;
    localparam logic [1:0] ST_EMPTY_WALK = 2'd3;

    // Input item
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] push_value;
    } t_req;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic               last_of_run;
    } t_result;

endpackage

`default_nettype wire

/* design/dq_ring.sv */
// dq_ring: item storage for the queue, one write port and one registered
// read port. Depends on dq_pkg for depth and pointer width.
`default_nettype none

module dq_ring (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [dq_pkg::PTR_W-1:0] i_waddr,
    input  wire logic signed [31:0]       i_wdata,
    input  wire logic [dq_pkg::PTR_W-1:0] i_raddr,
    output logic signed [31:0]            o_rdata
);

    logic signed [31:0] r_mem [dq_pkg::DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/double_ended_queue_top.sv */
// double_ended_queue_top: bounded deque in a ring buffer with a small
// sequencer around one shared ring-position adder. Depends on dq_pkg, dq_ring.
`default_nettype none

// Usage
//   Requests: drive i_req and raise start; the item is taken at a clock edge
//   where start is high and busy is low. Codes: push front/back, pop
//   front/back, walk. Unknown codes are taken and give no result.
//   Results: o_result_valid is high for exactly one cycle per result, in the
//   cycle after the item is taken (or after each storage read of a walk).
//   The receiver cannot stall; every result must be taken when shown.
//   Throughput: push and pop never raise busy and can run back to back.
//   A walk of N stored items reads the ring once per cycle and holds busy
//   high for its reads after the first; an empty-queue walk gives one result.
//   The storage read port (one read per cycle) sets the walk rate.
//   Full push reports overflow, empty pop reports underflow; neither changes
//   the queue. Walk marks its last result with last_of_run.
//   Reset (synchronous, active low) empties the queue and sets the head to
//   zero; storage contents are not cleared and need no clearing pass.
module double_ended_queue_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire dq_pkg::t_req    i_req,
    output logic                 busy,
    output logic                 o_result_valid,
    output dq_pkg::t_result      o_result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    // Ring position: (base + offset) mod DEPTH with one compare and subtract
    function automatic logic [dq_pkg::PTR_W-1:0] ring_add(
        input logic [dq_pkg::PTR_W-1:0] base,
        input logic [dq_pkg::CNT_W-1:0] off
    );
        logic [dq_pkg::CNT_W:0] sum;
        sum = {{(dq_pkg::CNT_W + 1 - dq_pkg::PTR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH)) begin
            sum = sum - (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH);
        end
        return sum[dq_pkg::PTR_W-1:0];
    endfunction

    logic                       r_state, n_state;
    logic [dq_pkg::PTR_W-1:0]   r_head, n_head;
    logic [dq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [dq_pkg::CNT_W-1:0]   r_walk_idx, n_walk_idx;

    logic                       r_out_valid, n_out_valid;
    logic [1:0]                 r_out_status, n_out_status;
    logic signed [31:0]         r_out_value, n_out_value;
    logic                       r_out_last, n_out_last;
    logic                       r_out_from_ram, n_out_from_ram;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [dq_pkg::CNT_W-1:0]   offset;
    logic [dq_pkg::PTR_W-1:0]   pos;
    logic                       we;
    logic [dq_pkg::PTR_W-1:0]   waddr;
    logic [dq_pkg::PTR_W-1:0]   raddr;
    logic signed [31:0]         rdata;

    assign busy   = (r_state == S_WALK);
    assign accept = start && !busy;
    assign full   = (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign empty  = (r_count == '0);

    // Offset into the ring for the shared position adder
    always_comb begin
        offset = '0;
        if (r_state == S_WALK) begin
            offset = r_walk_idx;
        end else begin
            case (i_req.req_type)
                dq_pkg::REQ_PUSH_BACK: offset = r_count;
                dq_pkg::REQ_POP_FRONT: offset = dq_pkg::CNT_W'(1);
                dq_pkg::REQ_POP_BACK:  offset = r_count - dq_pkg::CNT_W'(1);
                default:               offset = '0;
            endcase
        end
    end

    assign pos = ring_add(r_head, offset);

    // Sequencer: request decode and walk stepping
    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_count        = r_count;
        n_walk_idx     = r_walk_idx;
        n_out_valid    = 1'b0;
        n_out_status   = dq_pkg::ST_OK;
        n_out_value    = i_req.push_value;
        n_out_last     = 1'b1;
        n_out_from_ram = 1'b0;
        we             = 1'b0;
        waddr          = pos;
        raddr          = pos;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        dq_pkg::REQ_PUSH_FRONT: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_out_status = dq_pkg::ST_OVERFLOW;
                            end else begin
                                n_head  = (r_head == '0) ?
                                          dq_pkg::PTR_W'(dq_pkg::DEPTH - 1) :
                                          r_head - dq_pkg::PTR_W'(1);
                                waddr   = n_head;
                                we      = 1'b1;
                                n_count = r_count + dq_pkg::CNT_W'(1);
                            end
                        end
                        dq_pkg::REQ_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_out_status = dq_pkg::ST_OVERFLOW;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + dq_pkg::CNT_W'(1);
                            end
                        end
                        dq_pkg::REQ_POP_FRONT: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_out_status = dq_pkg::ST_UNDERFLOW;
                                n_out_value  = '0;
                            end else begin
                                raddr          = r_head;
                                n_head         = pos;
                                n_count        = r_count - dq_pkg::CNT_W'(1);
                                n_out_from_ram = 1'b1;
                            end
                        end
                        dq_pkg::REQ_POP_BACK: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_out_status = dq_pkg::ST_UNDERFLOW;
                                n_out_value  = '0;
                            end else begin
                                n_count        = r_count - dq_pkg::CNT_W'(1);
                                n_out_from_ram = 1'b1;
                            end
                        end
                        dq_pkg::REQ_WALK: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_out_status = dq_pkg::ST_EMPTY_WALK;
                                n_out_value  = '0;
                            end else begin
                                n_out_from_ram = 1'b1;
                                n_out_last     = (r_count == dq_pkg::CNT_W'(1));
                                n_walk_idx     = dq_pkg::CNT_W'(1);
                                if (r_count != dq_pkg::CNT_W'(1)) begin
                                    n_state = S_WALK;
                                end
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // one ring read per cycle, front to back
                n_out_valid    = 1'b1;
                n_out_from_ram = 1'b1;
                n_out_last     = (r_walk_idx == r_count - dq_pkg::CNT_W'(1));
                n_walk_idx     = r_walk_idx + dq_pkg::CNT_W'(1);
                if (n_out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_walk_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_walk_idx  <= n_walk_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_status   <= n_out_status;
        r_out_value    <= n_out_value;
        r_out_last     <= n_out_last;
        r_out_from_ram <= n_out_from_ram;
    end

    dq_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.push_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result ports
    assign o_result_valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.item_value    = r_out_from_ram ? rdata : r_out_value;
    assign o_result.last_of_run   = r_out_last;

endmodule

`default_nettype wire

/* design/dq_checker.sv */
// dq_checker: port-level checks on the queue's request and result timing,
// bound to double_ended_queue_top. Depends on dq_pkg.
`default_nettype none

module dq_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire dq_pkg::t_req    i_req,
    input wire logic            busy,
    input wire logic            o_result_valid,
    input wire dq_pkg::t_result o_result
);

    // A result follows a taken item or a walk step
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a preceding item or walk step");

    // Only a walk makes the block busy
    a_busy_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(i_req.req_type == dq_pkg::REQ_WALK))
        else $error("busy raised by a request other than walk");

    // Every busy cycle delivers a walk result in the next cycle
    a_walk_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_result_valid)
        else $error("walk step gave no result");

    // A result that is not last means the walk is still running
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last_of_run) |-> busy)
        else $error("non-final result while the block is idle");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .i_req          (i_req),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
